// File: sv/key_scan_debounce_long_press_unit_macros.svh
// assertion macros for the key scan debounce unit checker
// expects clk and rst in the scope of each use
`ifndef KEY_SCAN_DEBOUNCE_LONG_PRESS_UNIT_MACROS_SVH
`define KEY_SCAN_DEBOUNCE_LONG_PRESS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KSDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KSDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ksdlp_pkg.sv
// shared types and constants for the key scan debounce unit
// no dependencies
package ksdlp_pkg;

  localparam int KEY_COUNT = 6;
  localparam int KEY_BITS  = 6;
  localparam int SCAN_KEYS = (KEY_COUNT < KEY_BITS) ? KEY_COUNT : KEY_BITS;
  localparam int CODE_BITS = 3;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [7:0]  CONFIRM_RESET = 8'd10;
  localparam logic [7:0]  POLL_RESET    = 8'd10;
  localparam logic [15:0] LONG_RESET    = 16'd1000;

  localparam logic [CODE_BITS-1:0] KEY_RX       = 3'd5;
  localparam logic [CODE_BITS-1:0] CODE_RX_LONG = 3'd6;

  localparam logic [1:0] REG_CONFIRM = 2'd0;
  localparam logic [1:0] REG_POLL    = 2'd1;
  localparam logic [1:0] REG_LONG    = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_CONFIRM = 3'b010,
    PH_HOLD    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  confirm_delay_ticks;
    logic [7:0]  poll_interval_ticks;
    logic [15:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [CODE_BITS-1:0] code;
  } result_t;

endpackage

// File: sv/ksdlp_cfg_regs.sv
// apb configuration registers for the key scan debounce unit
// depends on ksdlp_pkg
module ksdlp_cfg_regs import ksdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.confirm_delay_ticks <= CONFIRM_RESET;
      cfg.poll_interval_ticks <= POLL_RESET;
      cfg.long_press_ticks    <= LONG_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CONFIRM: cfg.confirm_delay_ticks <= pwdata[7:0];
        REG_POLL:    cfg.poll_interval_ticks <= pwdata[7:0];
        REG_LONG:    cfg.long_press_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CONFIRM: prdata = {24'd0, cfg.confirm_delay_ticks};
      REG_POLL:    prdata = {24'd0, cfg.poll_interval_ticks};
      REG_LONG:    prdata = {16'd0, cfg.long_press_ticks};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: sv/ksdlp_scan_core.sv
// scan state machine: key latch, debounce confirm, release poll, long press
// depends on ksdlp_pkg
module ksdlp_scan_core import ksdlp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [KEY_BITS-1:0] keys,
  input  cfg_t                cfg,
  output result_t             res
);

  phase_t               phase, phase_next;
  logic [CODE_BITS-1:0] latched_key, latched_key_next;
  logic [7:0]           wait_count, wait_count_next;
  logic [15:0]          held_ticks, held_ticks_next;

  logic [7:0]           wc_inc;
  logic [15:0]          held_inc;
  logic                 latched_down;
  logic                 found;
  logic [CODE_BITS-1:0] first_key;

  assign wc_inc   = (wait_count == 8'hFF) ? wait_count : wait_count + 8'd1;
  assign held_inc = (held_ticks == 16'hFFFF) ? held_ticks : held_ticks + 16'd1;
  assign latched_down = keys[latched_key];

  // lowest pressed key wins
  always_comb begin
    found     = 1'b0;
    first_key = '0;
    for (int i = SCAN_KEYS - 1; i >= 0; i--) begin
      if (keys[i]) begin
        found     = 1'b1;
        first_key = CODE_BITS'(i);
      end
    end
  end

  always_comb begin
    phase_next       = phase;
    latched_key_next = latched_key;
    wait_count_next  = wait_count;
    held_ticks_next  = held_ticks;
    res.valid        = 1'b0;
    res.code         = latched_key;
    unique case (phase)
      PH_CONFIRM: begin
        if (wc_inc >= cfg.confirm_delay_ticks) begin
          wait_count_next = '0;
          if (latched_down) begin
            phase_next      = PH_HOLD;
            held_ticks_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          wait_count_next = wc_inc;
        end
      end
      PH_HOLD: begin
        held_ticks_next = held_inc;
        if (wc_inc >= cfg.poll_interval_ticks) begin
          wait_count_next = '0;
          if (!latched_down) begin
            phase_next = PH_IDLE;
            res.valid  = 1'b1;
            if (latched_key == KEY_RX && held_inc >= cfg.long_press_ticks) begin
              res.code = CODE_RX_LONG;
            end
          end
        end else begin
          wait_count_next = wc_inc;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (found) begin
          latched_key_next = first_key;
          wait_count_next  = '0;
          phase_next       = PH_CONFIRM;
        end
      end
    endcase
    res.valid = res.valid && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      latched_key <= '0;
      wait_count  <= '0;
      held_ticks  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      latched_key <= latched_key_next;
      wait_count  <= wait_count_next;
      held_ticks  <= held_ticks_next;
    end
  end

endmodule

// File: sv/ksdlp_out_buf.sv
// two-entry result buffer between the scan core and the output channel
// depends on ksdlp_pkg
module ksdlp_out_buf import ksdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  result_t              res,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] key_code
);

  logic [CODE_BITS-1:0] slot [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;

  assign push      = res.valid && !full;
  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign key_code  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= res.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: sv/key_scan_debounce_long_press_unit.sv
// key scanner with debounce and long-press detection, one tick per input transfer
// a result enters the result buffer when the releasing tick leaves the input register
// throughput: one tick per cycle; the input register stalls only when both
// result buffer entries are occupied
// reset (synchronous): scan state idle, counters zero, registers to 10, 10, 1000
// depends on ksdlp_pkg, ksdlp_cfg_regs, ksdlp_scan_core, ksdlp_out_buf
module key_scan_debounce_long_press_unit import ksdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_BITS-1:0]  keys_pressed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] key_code,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t                cfg;
  result_t             res;
  logic                buf_full;
  logic                s1_valid;
  logic [KEY_BITS-1:0] s1_keys;
  logic                advance;

  assign advance  = s1_valid && !buf_full;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_keys <= keys_pressed;
    end
  end

  ksdlp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ksdlp_scan_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .keys (s1_keys),
    .cfg  (cfg),
    .res  (res)
  );

  ksdlp_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_code  (key_code)
  );

endmodule

// File: sv/ksdlp_checker.sv
// port-level checker for the key scan debounce unit, bound to the top level
// depends on ksdlp_pkg and key_scan_debounce_long_press_unit_macros.svh
`include "key_scan_debounce_long_press_unit_macros.svh"

module ksdlp_checker import ksdlp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CODE_BITS-1:0] key_code,
  input logic                 pready
);

  `KSDLP_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
  `KSDLP_ASSERT_NOW(a_code_range, out_valid, key_code <= CODE_RX_LONG, "key code out of range")
  `KSDLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_code), "result changed while stalled")
  `KSDLP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `KSDLP_ASSERT_NOW(a_result_follows_transfer, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a matching input transfer")

endmodule

bind key_scan_debounce_long_press_unit ksdlp_checker u_ksdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_code  (key_code),
  .pready    (pready)
);
